// File: hdl/lzss_pkg.sv
package lzss_pkg;

    // match length is capped at the lookahead
    localparam int LOOKAHEAD  = 18;
    // match length is the low nibble plus this bias plus one
    localparam int MATCH_BIAS = 2;
    // position field of a match token
    localparam int POS_W      = 12;
    // remaining byte count of a match
    localparam int LEN_W      = 5;
    // fill byte of the lower part of the history at reset
    localparam logic [7:0] RESET_FILL = 8'h20;
    // marks loaded into the flag shifter with a new flag byte
    localparam logic [7:0] FLAG_MARKS = 8'hff;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_COPY,
        ST_LIT
    } state_t;

    // what the next compressed byte is
    typedef enum logic [1:0] {
        PH_TOKEN,
        PH_LIT,
        PH_LOW,
        PH_HIGH
    } phase_t;

endpackage

// File: hdl/lzss_ram.sv
module lzss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read that holds while re is low
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/lzss_decompressor.sv
// LZSS decoder with a history ring of RING_SIZE bytes and an 18-byte lookahead.
// Compressed bytes arrive one per beat on the s_axis channel; tlast marks the
// final byte of a stream and drops any partial token after that byte.
// Decoded bytes leave one per beat on m_axis; tlast is set on the last byte
// produced by one input byte (a literal, or the final byte of a match copy).
// Flag bytes and first match bytes produce nothing.
// A literal is held in lit_reg and loaded into the output register once that
// can take it; s_axis_tready stays low until it is loaded. A match folds the
// 12-bit position into the ring by repeated ring-size subtractions (none when
// RING_SIZE is 4096); the ring copy runs one byte per cycle while the output
// register can take a byte, through the registered ram read with
// a bypass for a byte written in the same cycle. At most 18 bytes per token.
// The output register lets the next input byte be taken while a result waits.
// When m_axis_tready is low the copy stalls with the pending byte held.
// After reset the ring reads as spaces below RING_SIZE-18 and zero above, by
// a fill count of written entries; there is no clearing pass and the block
// is ready as soon as reset is released.
module lzss_decompressor #(
    parameter int RING_SIZE = 4096
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
    input  logic       s_axis_tlast,  // in_last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,  // [7:0] out_byte
    output logic       m_axis_tlast   // out_last_of_run
);

    import lzss_pkg::*;

    localparam int AW = $clog2(RING_SIZE);
    localparam logic [AW-1:0]    START    = AW'(RING_SIZE - LOOKAHEAD);
    localparam logic [AW-1:0]    LAST_IDX = AW'(RING_SIZE - 1);
    localparam logic [AW:0]      FILL_MAX = (AW + 1)'(RING_SIZE);
    localparam logic [POS_W:0]   RING_W   = (POS_W + 1)'(RING_SIZE);
    localparam logic [LEN_W-1:0] LEN_OFS  = LEN_W'(MATCH_BIAS + 1);
    localparam logic [LEN_W-1:0] LEN_CAP  = LEN_W'(LOOKAHEAD);

    state_t           st_reg, st_next;
    phase_t           phase_reg, phase_next;
    logic [15:0]      flag_reg, flag_next;
    logic [7:0]       low_reg, low_next;
    logic [7:0]       lit_reg, lit_next;
    logic [POS_W-1:0] mod_reg, mod_next;
    logic [AW-1:0]    rd_addr_reg, rd_addr_next;
    logic [LEN_W-1:0] left_reg, left_next;
    logic             pend_reg, pend_next;
    logic             fwd_reg, fwd_next;
    logic [7:0]       fwd_byte_reg, fwd_byte_next;
    logic             hit_reg, hit_next;
    logic [7:0]       dflt_reg, dflt_next;
    logic [AW-1:0]    wp_reg, wp_next;
    logic [AW:0]      fill_reg, fill_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;

    logic             accept;
    logic             out_free;
    logic             consume;
    logic             issue;
    logic             load;
    logic             load_last;
    logic [7:0]       load_byte;
    logic [7:0]       pend_byte;
    logic [7:0]       ram_rdata;
    logic             mod_big;
    logic [15:0]      flag_sh;
    logic [15:0]      flag_tok;
    logic             flag_used;
    phase_t           phase_tok;
    logic [LEN_W-1:0] len_raw;
    logic [LEN_W-1:0] len_sat;
    logic [AW:0]      rd_ofs;

    // history ring
    lzss_ram #(
        .WIDTH (8),
        .DEPTH (RING_SIZE)
    ) u_ring (
        .clk   (clk),
        .we    (load),
        .waddr (wp_reg),
        .wdata (load_byte),
        .re    (issue),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    // token decode of the incoming byte
    always_comb
    begin
        flag_sh   = flag_reg >> 1;
        flag_tok  = flag_reg;
        flag_used = 1'b0;
        phase_tok = phase_reg;
        if (phase_reg == PH_TOKEN)
        begin
            if (!flag_sh[8])
            begin
                flag_tok  = {FLAG_MARKS, s_axis_tdata};
                flag_used = 1'b1;
            end
            else
            begin
                flag_tok = flag_sh;
            end
            phase_tok = flag_tok[0] ? PH_LIT : PH_LOW;
        end
        len_raw = {1'b0, s_axis_tdata[3:0]} + LEN_OFS;
        len_sat = (len_raw > LEN_CAP) ? LEN_CAP : len_raw;
    end

    // ring offset of the read address from the reset write position
    always_comb
    begin
        if (rd_addr_reg >= START)
        begin
            rd_ofs = {1'b0, rd_addr_reg} - {1'b0, START};
        end
        else
        begin
            rd_ofs = {1'b0, rd_addr_reg} + (AW + 1)'(LOOKAHEAD);
        end
    end

    // pending copy byte: bypass, written entry, or reset contents
    assign pend_byte = fwd_reg ? fwd_byte_reg : (hit_reg ? ram_rdata : dflt_reg);
    assign mod_big   = {1'b0, mod_reg} >= RING_W;

    // handshake and datapath strobes
    always_comb
    begin
        s_axis_tready = 1'b0;
        out_free      = !out_valid_reg || m_axis_tready;
        consume       = 1'b0;
        issue         = 1'b0;
        load          = 1'b0;
        load_last     = 1'b0;
        load_byte     = pend_byte;
        unique case (st_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            ST_MOD:
            begin
            end
            ST_COPY:
            begin
                consume   = pend_reg && out_free;
                issue     = (left_reg != '0) && (!pend_reg || consume);
                load      = consume;
                load_last = (left_reg == '0);
            end
            ST_LIT:
            begin
                load      = out_free;
                load_last = 1'b1;
                load_byte = lit_reg;
            end
            default:
            begin
            end
        endcase
        accept = s_axis_tready && s_axis_tvalid;
    end

    // next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (accept && !flag_used)
                begin
                    if (phase_tok == PH_LIT)
                    begin
                        st_next = ST_LIT;
                    end
                    else if (phase_tok == PH_HIGH)
                    begin
                        st_next = ST_MOD;
                    end
                end
            end
            ST_MOD:
            begin
                if (!mod_big)
                begin
                    st_next = ST_COPY;
                end
            end
            ST_COPY:
            begin
                if (consume && left_reg == '0)
                begin
                    st_next = ST_IDLE;
                end
            end
            ST_LIT:
            begin
                if (load)
                begin
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    // token state and copy datapath
    always_comb
    begin
        phase_next    = phase_reg;
        flag_next     = flag_reg;
        low_next      = low_reg;
        lit_next      = lit_reg;
        mod_next      = mod_reg;
        rd_addr_next  = rd_addr_reg;
        left_next     = left_reg;
        pend_next     = pend_reg;
        fwd_next      = fwd_reg;
        fwd_byte_next = fwd_byte_reg;
        hit_next      = hit_reg;
        dflt_next     = dflt_reg;
        wp_next       = wp_reg;
        fill_next     = fill_reg;

        // accepted byte
        if (accept)
        begin
            flag_next  = flag_tok;
            phase_next = phase_tok;
            if (!flag_used)
            begin
                unique case (phase_tok)
                    PH_LIT:
                    begin
                        lit_next   = s_axis_tdata;
                        phase_next = PH_TOKEN;
                    end
                    PH_LOW:
                    begin
                        low_next   = s_axis_tdata;
                        phase_next = PH_HIGH;
                    end
                    PH_HIGH:
                    begin
                        mod_next   = {s_axis_tdata[7:4], low_reg};
                        left_next  = len_sat;
                        phase_next = PH_TOKEN;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (s_axis_tlast)
            begin
                phase_next = PH_TOKEN;
                flag_next  = '0;
            end
        end

        // fold the match position into the ring
        if (st_reg == ST_MOD)
        begin
            if (mod_big)
            begin
                mod_next = mod_reg - RING_W[POS_W-1:0];
            end
            else
            begin
                rd_addr_next = mod_reg[AW-1:0];
                pend_next    = 1'b0;
            end
        end

        // ring read for the next copy byte
        if (issue)
        begin
            rd_addr_next  = (rd_addr_reg == LAST_IDX) ? '0 : rd_addr_reg + 1'b1;
            left_next     = left_reg - 1'b1;
            pend_next     = 1'b1;
            fwd_next      = consume && (rd_addr_reg == wp_reg);
            fwd_byte_next = pend_byte;
            hit_next      = rd_ofs < fill_reg;
            dflt_next     = (rd_addr_reg < START) ? RESET_FILL : 8'h00;
        end
        else if (consume)
        begin
            pend_next = 1'b0;
        end

        // ring write of each emitted byte
        if (load)
        begin
            wp_next   = (wp_reg == LAST_IDX) ? '0 : wp_reg + 1'b1;
            fill_next = (fill_reg == FILL_MAX) ? fill_reg : fill_reg + 1'b1;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = load_byte;
            out_last_next  = load_last;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            phase_reg     <= PH_TOKEN;
            flag_reg      <= '0;
            low_reg       <= '0;
            pend_reg      <= 1'b0;
            left_reg      <= '0;
            wp_reg        <= START;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            phase_reg     <= phase_next;
            flag_reg      <= flag_next;
            low_reg       <= low_next;
            pend_reg      <= pend_next;
            left_reg      <= left_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        lit_reg      <= lit_next;
        mod_reg      <= mod_next;
        rd_addr_reg  <= rd_addr_next;
        fwd_reg      <= fwd_next;
        fwd_byte_reg <= fwd_byte_next;
        hit_reg      <= hit_next;
        dflt_reg     <= dflt_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// File: tb/tb_lzss_decompressor.sv
import lzss_pkg::*;

// one decoded beat as the block should present it
typedef struct packed {
    logic [7:0] data;
    logic       last;
} decoded_t;

// shadow decoder: follows accepted compressed beats and queues the decoded beats
class decode_scoreboard;
    logic [7:0]  ring [0:4095];
    logic [11:0] wr_pos;
    logic [15:0] flags;
    phase_t      phase;
    logic [7:0]  match_low;
    decoded_t    decoded_q [$];
    int          errors;

    function new();
        for (int n = 0; n < 4096; n++)
            ring[n] = (n < 4096 - LOOKAHEAD) ? RESET_FILL : 8'h00;
        wr_pos    = 12'(4096 - LOOKAHEAD);
        flags     = '0;
        phase     = PH_TOKEN;
        match_low = '0;
        errors    = 0;
    endfunction

    // history write plus expected output beat
    function void put_decoded(logic [7:0] c, logic last);
        decoded_t d;
        ring[wr_pos] = c;
        wr_pos       = wr_pos + 12'd1;
        d.data       = c;
        d.last       = last;
        decoded_q.push_back(d);
    endfunction

    function void take_compressed(logic [7:0] b, logic in_last);
        logic        consumed;
        logic [11:0] rd;
        int          len;
        consumed = 1'b0;
        // new token: shift to the next flag, or load a fresh flag byte
        if (phase == PH_TOKEN)
        begin
            flags = flags >> 1;
            if (!flags[8])
            begin
                flags    = {FLAG_MARKS, b};
                consumed = 1'b1;
            end
            phase = flags[0] ? PH_LIT : PH_LOW;
        end
        if (!consumed)
        begin
            case (phase)
                PH_LIT:
                begin
                    put_decoded(b, 1'b1);
                    phase = PH_TOKEN;
                end
                PH_LOW:
                begin
                    match_low = b;
                    phase     = PH_HIGH;
                end
                PH_HIGH:
                begin
                    // copy one byte at a time so overlapping copies repeat output
                    rd  = {b[7:4], match_low};
                    len = b[3:0] + MATCH_BIAS + 1;
                    if (len > LOOKAHEAD)
                        len = LOOKAHEAD;
                    for (int k = 0; k < len; k++)
                    begin
                        put_decoded(ring[rd], k == len - 1);
                        rd = rd + 12'd1;
                    end
                    phase = PH_TOKEN;
                end
                default: ;
            endcase
        end
        // end of stream drops any partial token
        if (in_last)
        begin
            phase = PH_TOKEN;
            flags = '0;
        end
    endfunction

    function void check_decoded(logic [7:0] data, logic last);
        decoded_t want;
        if (decoded_q.size() == 0)
        begin
            $error("unexpected beat: out_byte=%02h out_last_of_run=%0b", data, last);
            errors++;
            return;
        end
        want = decoded_q.pop_front();
        if (data !== want.data)
        begin
            $error("out_byte: expected %02h, got %02h", want.data, data);
            errors++;
        end
        if (last !== want.last)
        begin
            $error("out_last_of_run: expected %0b, got %0b", want.last, last);
            errors++;
        end
    endfunction

    function int pending();
        return decoded_q.size();
    endfunction
endclass

module tb_lzss_decompressor;

    localparam int CYCLE_LIMIT = 300000;
    localparam int ITEM_TOTAL  = 160;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;

    decode_scoreboard sb;
    int tx_idle_pct = 25;
    int rx_idle_pct = 25;
    int sent        = 0;
    int cycles      = 0;

    lzss_decompressor dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // output side: random stall bursts
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(16, 1)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // output monitor
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_decoded(m_axis_tdata, m_axis_tlast);

    // one compressed beat, with an optional gap ahead of it
    task automatic send_beat(input logic [7:0] b, input logic last);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(16, 1)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
        sb.take_compressed(b, last);
        sent++;
    endtask

    task automatic send_match(input logic [11:0] pos, input logic [3:0] nib, input logic last);
        send_beat(pos[7:0], 1'b0);
        send_beat({pos[11:8], nib}, last);
    endtask

    // hold the input until every decoded beat has come out
    task automatic drain_output();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    // flag byte plus its eight tokens; broken cuts it short with tlast
    task automatic send_group(input bit broken, input bit closes);
        logic [7:0]  flag_byte;
        logic [11:0] pos;
        logic [3:0]  nib;
        int          n_bytes;
        int          stop;
        int          idx;
        flag_byte = 8'($urandom);
        n_bytes   = 1;
        for (int t = 0; t < 8; t++)
            n_bytes += flag_byte[t] ? 1 : 2;
        if (broken)
            stop = $urandom_range(n_bytes - 2, 0);
        else
            stop = n_bytes - 1;
        send_beat(flag_byte, (broken || closes) && stop == 0);
        idx = 1;
        for (int t = 0; t < 8 && idx <= stop; t++)
        begin
            if (flag_byte[t])
            begin
                send_beat(8'($urandom), (broken || closes) && idx == stop);
                idx++;
            end
            else
            begin
                // mostly short distances so copies overlap recent output
                if ($urandom_range(9) < 6)
                    pos = sb.wr_pos - 12'($urandom_range(20, 1));
                else
                    pos = 12'($urandom);
                nib = 4'($urandom);
                send_beat(pos[7:0], (broken || closes) && idx == stop);
                idx++;
                if (idx <= stop)
                begin
                    send_beat({pos[11:8], nib}, (broken || closes) && idx == stop);
                    idx++;
                end
            end
        end
    endtask

    // raw bytes, closed with tlast to get back in step
    task automatic send_noise();
        int n;
        n = $urandom_range(6, 1);
        for (int i = 0; i < n; i++)
            send_beat(8'($urandom), i == n - 1 || $urandom_range(3) == 0);
    endtask

    initial
    begin
        int pick;
        sb = new();
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tlast  <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: flags lit lit match match match lit lit match
        send_beat(8'h63, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'hff, 1'b0);
        // copy across the top of the ring, from the never-written zero area
        send_match(12'hfff, 4'h0, 1'b0);
        // longest copy overlapping the write position
        send_match(sb.wr_pos - 12'd1, 4'hf, 1'b0);
        send_match(12'h000, 4'hf, 1'b0);
        send_beat(8'ha5, 1'b0);
        send_beat(8'h5a, 1'b0);
        // end of stream inside a match token drops it
        send_beat(8'h12, 1'b1);
        // end of stream on a flag byte
        send_beat(8'h00, 1'b1);
        // end of stream on a literal
        send_beat(8'hff, 1'b0);
        send_beat(8'h3c, 1'b1);
        // end of stream on a match
        send_beat(8'h00, 1'b0);
        send_match(12'd4080, 4'h3, 1'b0);
        send_match(12'h0f0, 4'h7, 1'b1);

        drain_output();

        // random streams
        while (sent < ITEM_TOTAL)
        begin
            if (sent < 80)
            begin
                tx_idle_pct = 30;
                rx_idle_pct = 30;
            end
            else if (sent < 110)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            else if (sent < ITEM_TOTAL - 35)
            begin
                tx_idle_pct = 10;
                rx_idle_pct = 50;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            pick = $urandom_range(9);
            if (pick == 0)
                send_noise();
            else
                send_group(pick == 1, pick < 4);
        end

        // wind down
        drain_output();
        repeat (40) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: filelist.f
hdl/lzss_pkg.sv
hdl/lzss_ram.sv
hdl/lzss_decompressor.sv
tb/tb_lzss_decompressor.sv
